>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers on clk with asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/u8vs_pkg.sv
// ----------------------------------------------------------------------------
// u8vs_pkg
// shared types and sizes of the utf-8 validate and sanitize core
// ----------------------------------------------------------------------------
package u8vs_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
    localparam int BURST_CNT_W = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [BURST_CNT_W-1:0]   count;
        item_t [MAX_RESULTS-1:0]  items;
    } burst_t;

endpackage

>>> hw/rtl/u8vs_decode.sv
// ----------------------------------------------------------------------------
// u8vs_decode
// utf-8 sequence checker; turns each accepted byte into a burst of results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8vs_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            end_of_text,
    output u8vs_pkg::burst_t burst
);
    import u8vs_pkg::*;

    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] QMARK     = 8'h3F;

    logic [7:0]  held_reg [0:2];
    logic [1:0]  held_cnt_reg, held_cnt_next;
    logic [1:0]  need_reg, need_next;
    logic [20:0] cp_reg, cp_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  hi_reg, hi_next;
    logic        drop_reg, drop_next;

    logic        held_wr;
    logic [1:0]  held_idx;
    logic [20:0] cp_new;
    logic [1:0]  need_new;
    logic        complete;
    logic        fail;

    function automatic logic must_replace(input logic [20:0] c);
        return (c < 21'd32 && c != 21'd10) ||
               (c >= 21'd127 && c <= 21'd159) ||
               (c >= 21'h0202A && c <= 21'h0202E) ||
               (c >= 21'h02066 && c <= 21'h02069);
    endfunction

    always_comb
    begin
        held_cnt_next = held_cnt_reg;
        need_next     = need_reg;
        cp_next       = cp_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        drop_next     = drop_reg;
        held_wr       = 1'b0;
        held_idx      = 2'd0;
        cp_new        = cp_reg;
        need_new      = need_reg;
        complete      = 1'b0;
        fail          = 1'b0;
        burst         = '0;

        if (accept)
        begin
            if (drop_reg)
            begin
                if (end_of_text)
                begin
                    drop_next     = 1'b0;
                    held_cnt_next = 2'd0;
                    need_next     = 2'd0;
                    cp_next       = '0;
                    lo_next       = CONT_LO;
                    hi_next       = CONT_HI;
                end
            end
            else
            begin
                if (need_reg == 2'd0)
                begin
                    // lead byte
                    lo_next = CONT_LO;
                    hi_next = CONT_HI;
                    if (in_byte < 8'h80)
                    begin
                        cp_new   = {13'd0, in_byte};
                        complete = 1'b1;
                    end
                    else if (in_byte >= 8'hC2 && in_byte <= 8'hDF)
                    begin
                        cp_new   = {16'd0, in_byte[4:0]};
                        need_new = 2'd1;
                    end
                    else if (in_byte >= 8'hE0 && in_byte <= 8'hEF)
                    begin
                        cp_new   = {17'd0, in_byte[3:0]};
                        need_new = 2'd2;
                        if (in_byte == 8'hE0)
                        begin
                            lo_next = 8'hA0;
                        end
                        if (in_byte == 8'hED)
                        begin
                            hi_next = 8'h9F;
                        end
                    end
                    else if (in_byte >= 8'hF0 && in_byte <= 8'hF4)
                    begin
                        cp_new   = {18'd0, in_byte[2:0]};
                        need_new = 2'd3;
                        if (in_byte == 8'hF0)
                        begin
                            lo_next = 8'h90;
                        end
                        if (in_byte == 8'hF4)
                        begin
                            hi_next = 8'h8F;
                        end
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                    if (!fail && !complete)
                    begin
                        held_wr       = 1'b1;
                        held_idx      = 2'd0;
                        held_cnt_next = 2'd1;
                        if (end_of_text)
                        begin
                            fail = 1'b1;
                        end
                    end
                end
                else
                begin
                    // continuation byte
                    if (in_byte < lo_reg || in_byte > hi_reg)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        lo_next  = CONT_LO;
                        hi_next  = CONT_HI;
                        cp_new   = {cp_reg[14:0], in_byte[5:0]};
                        need_new = need_reg - 2'd1;
                        if (need_new != 2'd0)
                        begin
                            held_wr  = 1'b1;
                            held_idx = (held_cnt_reg == 2'd3) ? 2'd0 : held_cnt_reg;
                            if (held_cnt_reg != 2'd3)
                            begin
                                held_cnt_next = held_cnt_reg + 2'd1;
                            end
                            if (end_of_text)
                            begin
                                fail = 1'b1;
                            end
                        end
                        else
                        begin
                            complete = 1'b1;
                        end
                    end
                end

                cp_next   = cp_new;
                need_next = need_new;

                if (complete)
                begin
                    if (must_replace(cp_new))
                    begin
                        burst.count         = BURST_CNT_W'(1);
                        burst.items[0].data = QMARK;
                        burst.items[0].last = end_of_text;
                    end
                    else
                    begin
                        burst.count = BURST_CNT_W'(held_cnt_reg) + BURST_CNT_W'(1);
                        for (int k = 0; k < 3; k++)
                        begin
                            burst.items[k].data = (2'(k) < held_cnt_reg) ? held_reg[k] : in_byte;
                            burst.items[k].last = (2'(k) == held_cnt_reg) && end_of_text;
                        end
                        burst.items[3].data = in_byte;
                        burst.items[3].last = (held_cnt_reg == 2'd3) && end_of_text;
                    end
                end

                if (complete || fail)
                begin
                    held_cnt_next = 2'd0;
                    need_next     = 2'd0;
                    cp_next       = '0;
                    lo_next       = CONT_LO;
                    hi_next       = CONT_HI;
                end

                if (fail)
                begin
                    drop_next           = !end_of_text;
                    burst               = '0;
                    burst.count         = BURST_CNT_W'(1);
                    burst.items[0].bad  = 1'b1;
                    burst.items[0].last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            need_reg     <= 2'd0;
            cp_reg       <= '0;
            lo_reg       <= CONT_LO;
            hi_reg       <= CONT_HI;
            drop_reg     <= 1'b0;
        end
        else
        begin
            held_cnt_reg <= held_cnt_next;
            need_reg     <= need_next;
            cp_reg       <= cp_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            drop_reg     <= drop_next;
        end
    end

    // held bytes of the open sequence
    always_ff @(posedge clk)
    begin
        if (held_wr)
        begin
            held_reg[held_idx] <= in_byte;
        end
    end

    `ASSERT_NOW(a_drop_silent, accept && drop_reg, burst.count == '0,
        "byte produced results while dropping")
    `ASSERT_NOW(a_eot_answers, accept && end_of_text && !drop_reg, burst.count != '0,
        "final byte of a text produced no result")
    `ASSERT_NOW(a_open_has_lead, need_reg != 2'd0, held_cnt_reg != 2'd0,
        "open sequence without a held lead byte")

endmodule

>>> hw/rtl/u8vs_outq.sv
// ----------------------------------------------------------------------------
// u8vs_outq
// shifting result queue; takes up to four beats, on ready drains one a cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8vs_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  u8vs_pkg::burst_t burst,
    output logic             space_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             bad_text,
    output logic             last_out
);
    import u8vs_pkg::*;

    item_t                 ent_reg  [OUTQ_DEPTH];
    item_t                 ent_next [OUTQ_DEPTH];
    logic [OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OUTQ_CNT_W-1:0] base;
    logic [OUTQ_CNT_W-1:0] off;
    logic                  pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign space_ok  = (cnt_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - MAX_RESULTS));
    assign out_byte  = ent_reg[0].data;
    assign bad_text  = ent_reg[0].bad;
    assign last_out  = ent_reg[0].last;

    always_comb
    begin
        base     = cnt_reg - OUTQ_CNT_W'(pop);
        cnt_next = base + OUTQ_CNT_W'(burst.count);
        off      = '0;
        for (int i = 0; i < OUTQ_DEPTH; i++)
        begin
            off = OUTQ_CNT_W'(i) - base;
            if (OUTQ_CNT_W'(i) < base)
            begin
                ent_next[i] = pop ? ent_reg[(i == OUTQ_DEPTH - 1) ? i : i + 1] : ent_reg[i];
            end
            else if (off < OUTQ_CNT_W'(burst.count))
            begin
                ent_next[i] = burst.items[off[$clog2(MAX_RESULTS)-1:0]];
            end
            else
            begin
                ent_next[i] = ent_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < OUTQ_DEPTH; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
    end

    `ASSERT_NOW(a_no_overflow, 1'b1, cnt_reg <= OUTQ_CNT_W'(OUTQ_DEPTH),
        "result queue overflow")
    `ASSERT_NEXT(a_drain_one, pop && burst.count == '0,
        cnt_reg == $past(cnt_reg) - OUTQ_CNT_W'(1),
        "queue count did not drop by one on a lone pop")
    `ASSERT_NOW(a_error_beat, out_valid && bad_text, last_out && out_byte == 8'd0,
        "error beat must be last and carry a zero byte")

endmodule

>>> hw/rtl/utf8_validate_sanitize_core.sv
// ----------------------------------------------------------------------------
// utf8_validate_sanitize_core
// strict utf-8 checker and sanitizer for a byte stream
// ----------------------------------------------------------------------------
// One input byte is taken per cycle whenever the eight-beat result queue has
// room for four more beats; in_ready follows only the queue fill level, so it
// never waits on out_ready combinationally. Each byte is checked in the cycle
// it is taken and yields zero to four result beats at once (the held bytes of
// a finished code point plus the last byte, a single '?', or one error beat),
// which the queue drains one per ready cycle. Over a text there are never more
// result beats than input bytes, so one byte per cycle is sustained when the
// downstream side takes a beat every cycle. After an error beat the rest of
// the text is dropped without results up to the byte marked end_of_text.
// ----------------------------------------------------------------------------
module utf8_validate_sanitize_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       bad_text,
    output logic       last_out
);
    import u8vs_pkg::*;

    burst_t burst;
    logic   accept;

    assign accept = in_valid && in_ready;

    u8vs_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .burst       (burst)
    );

    u8vs_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .burst     (burst),
        .space_ok  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .bad_text  (bad_text),
        .last_out  (last_out)
    );

endmodule

>>> dv/utf8_sanitize_checker.sv
// ----------------------------------------------------------------------------
// utf8_sanitize_checker
// watches both channels of the utf-8 sanitize core, predicts the result beats
// of every accepted input byte and compares them in order
// ----------------------------------------------------------------------------
module utf8_sanitize_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       bad_text,
    input  logic       last_out,
    output int         fail_count,
    output int         open_beats
);
    import u8vs_pkg::*;

    item_t       expected_beats[$];
    int          mismatches;

    logic [7:0]  seq_bytes [3];
    logic [1:0]  seq_held;
    logic [1:0]  seq_needed;
    logic [20:0] seq_value;
    logic [7:0]  next_low;
    logic [7:0]  next_high;
    logic        skipping;

    function automatic item_t beat_of(logic [7:0] data, logic bad, logic last);
        item_t beat;
        beat.data = data;
        beat.bad  = bad;
        beat.last = last;
        return beat;
    endfunction

    function automatic bit needs_placeholder(logic [20:0] c);
        return (c < 21'd32 && c != 21'h0A) ||
               (c >= 21'd127 && c <= 21'd159) ||
               (c >= 21'h202A && c <= 21'h202E) ||
               (c >= 21'h2066 && c <= 21'h2069);
    endfunction

    task automatic clear_sequence();
        seq_held   = 2'd0;
        seq_needed = 2'd0;
        seq_value  = 21'd0;
        next_low   = 8'h80;
        next_high  = 8'hBF;
    endtask

    task automatic add_beat(input item_t beat);
        expected_beats.insert(expected_beats.size(), beat);
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic sanitize_byte(input logic [7:0] b, input logic eot);
        bit complete;
        bit bad;
        int k;
        complete = 1'b0;
        bad      = 1'b0;
        if (skipping)
        begin
            if (eot)
            begin
                skipping = 1'b0;
                clear_sequence();
            end
            return;
        end
        if (seq_needed == 2'd0)
        begin
            next_low  = 8'h80;
            next_high = 8'hBF;
            if (b < 8'h80)
            begin
                seq_value = {13'd0, b};
                complete  = 1'b1;
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                seq_value  = {16'd0, b[4:0]};
                seq_needed = 2'd1;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                seq_value  = {17'd0, b[3:0]};
                seq_needed = 2'd2;
                if (b == 8'hE0)
                    next_low = 8'hA0;
                if (b == 8'hED)
                    next_high = 8'h9F;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                seq_value  = {18'd0, b[2:0]};
                seq_needed = 2'd3;
                if (b == 8'hF0)
                    next_low = 8'h90;
                if (b == 8'hF4)
                    next_high = 8'h8F;
            end
            else
                bad = 1'b1;
            if (!bad && !complete)
            begin
                seq_bytes[0] = b;
                seq_held     = 2'd1;
                if (eot)
                    bad = 1'b1;
            end
        end
        else if (b < next_low || b > next_high)
            bad = 1'b1;
        else
        begin
            next_low   = 8'h80;
            next_high  = 8'hBF;
            seq_value  = {seq_value[14:0], b[5:0]};
            seq_needed = seq_needed - 2'd1;
            if (seq_needed == 2'd0)
                complete = 1'b1;
            else
            begin
                seq_bytes[seq_held] = b;
                seq_held = seq_held + 2'd1;
                if (eot)
                    bad = 1'b1;
            end
        end
        if (bad)
        begin
            clear_sequence();
            skipping = !eot;
            add_beat(beat_of(8'h00, 1'b1, 1'b1));
        end
        else if (complete)
        begin
            if (needs_placeholder(seq_value))
                add_beat(beat_of(8'h3F, 1'b0, eot));
            else
            begin
                for (k = 0; k < seq_held; k++)
                    add_beat(beat_of(seq_bytes[k], 1'b0, 1'b0));
                add_beat(beat_of(b, 1'b0, eot));
            end
            clear_sequence();
        end
    endtask

    task automatic compare_beat();
        item_t want;
        if (expected_beats.size() == 0)
        begin
            flag_mismatch($sformatf("beat %h/%b/%b with nothing expected",
                                    out_byte, bad_text, last_out));
            return;
        end
        want = expected_beats.pop_front();
        if (out_byte !== want.data)
            flag_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.data));
        if (bad_text !== want.bad)
            flag_mismatch($sformatf("bad_text %b, expected %b", bad_text, want.bad));
        if (last_out !== want.last)
            flag_mismatch($sformatf("last_out %b, expected %b", last_out, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_beats.delete();
            mismatches = 0;
            skipping   = 1'b0;
            clear_sequence();
            fail_count <= 0;
            open_beats <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                sanitize_byte(in_byte, end_of_text);
            if (out_valid && out_ready)
                compare_beat();
            fail_count <= mismatches;
            open_beats <= expected_beats.size();
        end
    end

endmodule

>>> dv/tb_utf8_validate_sanitize_core.sv
// ----------------------------------------------------------------------------
// tb_utf8_validate_sanitize_core
// drives texts into the utf-8 sanitize core: a directed set of edge cases,
// then random texts of well-formed code points mixed with controls, bidi
// marks, stray bytes and cut-off sequences, with random gaps on both sides
// ----------------------------------------------------------------------------
module tb_utf8_validate_sanitize_core;

    localparam int RANDOM_BYTES = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 36;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte     = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] out_byte;
    logic       bad_text;
    logic       last_out;

    int         fail_count;
    int         open_beats;
    int         stall_cycles;
    int         sent_bytes;
    int         cp_count;
    bit         gaps_on = 1'b1;
    bit         paused  = 1'b0;
    logic [7:0] text_bytes[$];

    utf8_validate_sanitize_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .bad_text    (bad_text),
        .last_out    (last_out)
    );

    utf8_sanitize_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .bad_text    (bad_text),
        .last_out    (last_out),
        .fail_count  (fail_count),
        .open_beats  (open_beats)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (gaps_on)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text();
        int k;
        for (k = 0; k < text_bytes.size(); k++)
            send_byte(text_bytes[k], k == text_bytes.size() - 1);
        sent_bytes += text_bytes.size();
        text_bytes.delete();
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (open_beats != 0);
    endtask

    task automatic add_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endtask

    task automatic push_code_point();
        int         kind;
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        kind = $urandom_range(0, 99);
        if (kind < 30)
            add_byte(8'($urandom_range(0, 127)));
        else if (kind < 45)
        begin
            add_byte(8'($urandom_range(8'hC2, 8'hDF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (kind < 65)
        begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            lo   = (lead == 8'hE0) ? 8'hA0 : 8'h80;
            hi   = (lead == 8'hED) ? 8'h9F : 8'hBF;
            add_byte(lead);
            add_byte(8'($urandom_range(lo, hi)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (kind < 78)
        begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            lo   = (lead == 8'hF0) ? 8'h90 : 8'h80;
            hi   = (lead == 8'hF4) ? 8'h8F : 8'hBF;
            add_byte(lead);
            add_byte(8'($urandom_range(lo, hi)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (kind < 84)
        begin
            add_byte(8'hC2);
            add_byte(8'($urandom_range(8'h80, 8'h9F)));
        end
        else if (kind < 90)
        begin
            add_byte(8'hE2);
            if ($urandom_range(0, 1) == 0)
            begin
                add_byte(8'h80);
                add_byte(8'($urandom_range(8'hAA, 8'hAE)));
            end
            else
            begin
                add_byte(8'h81);
                add_byte(8'($urandom_range(8'hA6, 8'hA9)));
            end
        end
        else
            add_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        sent_bytes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ascii, newline, controls, c1, kept 2-byte, bidi mark, highest code point
        text_bytes = '{8'h41, 8'h0A, 8'h00, 8'h7F, 8'hC2, 8'h80, 8'hC2, 8'hA9,
                       8'hE2, 8'h80, 8'hAA, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();
        // overlong after e0, rest of text dropped
        text_bytes = '{8'hE0, 8'h9F, 8'h41};
        send_text();
        // surrogate, error on the final byte
        text_bytes = '{8'hED, 8'hA0};
        send_text();
        // bad lead byte
        text_bytes = '{8'hF5};
        send_text();
        // sequence left open at end of text
        text_bytes = '{8'hE2, 8'h80};
        send_text();
        wait_drain();

        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES)
        begin
            gaps_on = !(sent_bytes >= 30 && sent_bytes < 60);
            if (!paused && sent_bytes >= 50)
            begin
                wait_drain();
                paused = 1'b1;
            end
            cp_count = $urandom_range(1, 6);
            repeat (cp_count) push_code_point();
            if ($urandom_range(0, 9) == 0 && text_bytes.size() > 1)
                void'(text_bytes.pop_back());
            send_text();
        end
        gaps_on = 1'b1;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && open_beats == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
